FILE: src/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared types, field widths and helpers for the sprite box collision table.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int SPRITE_SLOTS_DEF = 64;
  localparam int GROUP_COUNT_DEF  = 16;

  localparam int SLOT_W   = 6;
  localparam int POS_W    = 24;
  localparam int SIZE_W   = 13;
  localparam int SCALE_W  = 16;
  localparam int GROUP_W  = 4;
  localparam int SIZE_MAX = 4096;
  // saturated size times scale stays below 2**28
  localparam int PROD_W   = 28;
  // position plus scaled extent, signed
  localparam int EDGE_W   = PROD_W + 2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DELETE = 2'd1,
    OP_PAIR   = 2'd2,
    OP_FIRST  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_WRITE,
    S_DELETE,
    S_RD_A,
    S_RD_B,
    S_PAIR,
    S_QUERY,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [SLOT_W-1:0]        slot;
    logic [SLOT_W-1:0]        other_slot;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        size_w;
    logic [SIZE_W-1:0]        size_h;
    logic [SCALE_W-1:0]       scale_x;
    logic [SCALE_W-1:0]       scale_y;
    logic                     visible;
    logic [GROUP_W-1:0]       group;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              status;
  } rsp_t;

  // box kept as its edges left, right, top and bottom, extents folded in when written
  typedef struct packed {
    logic signed [POS_W-1:0]  left;
    logic signed [EDGE_W-1:0] right;
    logic signed [POS_W-1:0]  top;
    logic signed [EDGE_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic               used;
    logic               vis;
    logic [GROUP_W-1:0] grp;
  } flag_t;

  typedef struct packed {
    logic data_en;
    logic flag_en;
  } mem_wr_t;

  function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (int'(v) > SIZE_MAX) begin
      r = SIZE_W'(SIZE_MAX);
    end
    return r;
  endfunction

  // reduce a group number below n, at most eight subtract steps for n >= 2
  function automatic logic [GROUP_W-1:0] group_mod(input logic [GROUP_W-1:0] g,
                                                   input int n);
    logic [GROUP_W-1:0] v;
    v = g;
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= n) begin
        v = v - GROUP_W'(n);
      end
    end
    return v;
  endfunction

endpackage

FILE: src/sbct_slot_mem.sv
// ----------------------------------------------------------------------------
// sbct_slot_mem
// Slot storage: box edges and slot flags, one write and one registered read.
// ----------------------------------------------------------------------------
module sbct_slot_mem #(
  parameter int SPRITE_SLOTS = sbct_pkg::SPRITE_SLOTS_DEF,
  parameter int IDX_W        = $clog2(SPRITE_SLOTS)
) (
  input  logic              clk,
  input  sbct_pkg::mem_wr_t wr,
  input  logic [IDX_W-1:0]  waddr,
  input  sbct_pkg::box_t    wbox,
  input  sbct_pkg::flag_t   wflag,
  input  logic [IDX_W-1:0]  raddr,
  output sbct_pkg::box_t    rbox,
  output sbct_pkg::flag_t   rflag
);
  import sbct_pkg::*;

  box_t  data_mem [SPRITE_SLOTS];
  flag_t flag_mem [SPRITE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.data_en) begin
      data_mem[waddr] <= wbox;
    end
    if (wr.flag_en) begin
      flag_mem[waddr] <= wflag;
    end
  end

  always_ff @(posedge clk) begin
    rbox  <= data_mem[raddr];
    rflag <= flag_mem[raddr];
  end

endmodule

FILE: src/sbct_scale_mul.sv
// ----------------------------------------------------------------------------
// sbct_scale_mul
// Shared size times scale multiplier with a registered product.
// ----------------------------------------------------------------------------
module sbct_scale_mul (
  input  logic                         clk,
  input  logic [sbct_pkg::SIZE_W-1:0]  size,
  input  logic [sbct_pkg::SCALE_W-1:0] scale,
  output logic [sbct_pkg::PROD_W-1:0]  prod
);
  import sbct_pkg::*;

  logic [PROD_W-1:0] full;

  // saturated size keeps the product inside PROD_W bits
  assign full = PROD_W'(size) * PROD_W'(scale);

  always_ff @(posedge clk) begin
    prod <= full;
  end

endmodule

FILE: src/sbct_overlap.sv
// ----------------------------------------------------------------------------
// sbct_overlap
// Shared box overlap compare: four signed edge compares.
// ----------------------------------------------------------------------------
module sbct_overlap (
  input  sbct_pkg::box_t a,
  input  sbct_pkg::box_t b,
  output logic           overlap
);
  import sbct_pkg::*;

  logic signed [EDGE_W-1:0] a_left, a_top, b_left, b_top;

  assign a_left = EDGE_W'(a.left);
  assign a_top  = EDGE_W'(a.top);
  assign b_left = EDGE_W'(b.left);
  assign b_top  = EDGE_W'(b.top);

  assign overlap = (a_left < b.right) && (a.right > b_left) &&
                   (a_top < b.bottom) && (a.bottom > b_top);

endmodule

FILE: src/sprite_box_collision_table_unit.sv
// write runs the x and y multiply steps, then the slot write; delete clears the flags;
// pair test reads both slots; first-hit query scans, one slot compare a cycle
// through the single read port of the slot memory and the shared compare unit
// one word at a time: the next word is taken once the sequencer is idle again
// reset: synchronous, then a clearing pass over all slot flags
// ----------------------------------------------------------------------------
// sprite_box_collision_table_unit
// Sprite slot table with write, delete, pair overlap test and first-hit scan.
// ----------------------------------------------------------------------------
module sprite_box_collision_table_unit #(
  parameter int SPRITE_SLOTS = sbct_pkg::SPRITE_SLOTS_DEF,
  parameter int GROUP_COUNT  = sbct_pkg::GROUP_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sbct_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sbct_pkg::rsp_t rsp
);
  import sbct_pkg::*;

  localparam int IDX_W = $clog2(SPRITE_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SPRITE_SLOTS - 1);

  state_t state, state_next;
  req_t   req_r;

  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] cand_idx;
  logic [IDX_W-1:0] s_idx, t_idx;
  logic             slot_ok, other_ok;
  logic [GROUP_W-1:0] g;

  mem_wr_t          wr;
  logic [IDX_W-1:0] waddr, raddr;
  box_t             wbox, rbox, a_box;
  flag_t            wflag, rflag, a_flag;

  logic [SIZE_W-1:0]        mul_size;
  logic [SCALE_W-1:0]       mul_scale;
  logic [PROD_W-1:0]        prod;
  logic signed [POS_W-1:0]  edge_pos;
  logic signed [EDGE_W-1:0] edge_sum;
  logic signed [EDGE_W-1:0] rx;

  logic overlap;
  logic cand_match;
  logic pair_live;
  logic rsp_load;

  logic             res_hit, res_status;
  logic [SLOT_W-1:0] res_slot;

  assign s_idx    = IDX_W'(req_r.slot);
  assign t_idx    = IDX_W'(req_r.other_slot);
  assign slot_ok  = int'(req_r.slot) < SPRITE_SLOTS;
  assign other_ok = int'(req_r.other_slot) < SPRITE_SLOTS;
  assign g        = group_mod(req_r.group, GROUP_COUNT);

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_RESULT) && (!rsp_valid || !rsp_stall);

  // x extent in the first multiply step, y extent in the second
  assign mul_size  = (state == S_MUL_X) ? size_sat(req_r.size_w) : size_sat(req_r.size_h);
  assign mul_scale = (state == S_MUL_X) ? req_r.scale_x : req_r.scale_y;
  assign edge_pos  = (state == S_WRITE) ? req_r.pos_y : req_r.pos_x;
  assign edge_sum  = EDGE_W'(edge_pos) + signed'(EDGE_W'(prod));

  assign wbox = '{left: req_r.pos_x, right: rx, top: req_r.pos_y, bottom: edge_sum};

  assign pair_live  = slot_ok && a_flag.used && other_ok && rflag.used;
  assign cand_match = (cand_idx != s_idx) && rflag.used && rflag.vis &&
                      (rflag.grp == g) && overlap;

  sbct_scale_mul u_mul (
    .clk   (clk),
    .size  (mul_size),
    .scale (mul_scale),
    .prod  (prod)
  );

  sbct_overlap u_overlap (
    .a       (a_box),
    .b       (rbox),
    .overlap (overlap)
  );

  sbct_slot_mem #(
    .SPRITE_SLOTS (SPRITE_SLOTS),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .wbox  (wbox),
    .wflag (wflag),
    .raddr (raddr),
    .rbox  (rbox),
    .rflag (rflag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    waddr      = s_idx;
    wflag      = '0;
    raddr      = s_idx;
    unique case (state)
      S_CLEAR: begin
        wr.flag_en = 1'b1;
        waddr      = clr_idx;
        if (clr_idx == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            OP_WRITE:  state_next = S_MUL_X;
            OP_DELETE: state_next = S_DELETE;
            OP_PAIR:   state_next = S_RD_A;
            OP_FIRST:  state_next = S_RD_A;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_X: state_next = S_MUL_Y;
      S_MUL_Y: state_next = S_WRITE;
      S_WRITE: begin
        wr.data_en = slot_ok;
        wr.flag_en = slot_ok;
        wflag      = '{used: 1'b1, vis: req_r.visible, grp: g};
        state_next = S_IDLE;
      end
      S_DELETE: begin
        wr.flag_en = slot_ok;
        state_next = S_IDLE;
      end
      S_RD_A: begin
        state_next = (req_r.op == OP_PAIR) ? S_RD_B : S_QUERY;
      end
      S_RD_B: begin
        raddr      = t_idx;
        state_next = S_PAIR;
      end
      S_PAIR: state_next = S_RESULT;
      S_QUERY: begin
        raddr = '0;
        if (!slot_ok || !rflag.used || !rflag.vis) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // next candidate address goes out while this one is compared
        raddr = cand_idx + 1'b1;
        if (cand_match || cand_idx == LAST) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_r <= req;
    end
    if (state == S_MUL_Y) begin
      rx <= edge_sum;
    end
    if (state == S_RD_B || state == S_QUERY) begin
      a_box  <= rbox;
      a_flag <= rflag;
    end
    if (state == S_QUERY) begin
      cand_idx   <= '0;
      res_hit    <= 1'b0;
      res_slot   <= '0;
      res_status <= !(slot_ok && rflag.used);
    end
    if (state == S_SCAN) begin
      cand_idx <= cand_idx + 1'b1;
      if (cand_match) begin
        res_hit  <= 1'b1;
        res_slot <= SLOT_W'(cand_idx);
      end
    end
    if (state == S_PAIR) begin
      res_hit    <= pair_live && a_flag.vis && rflag.vis && overlap;
      res_slot   <= '0;
      res_status <= !pair_live;
    end
    if (rsp_load) begin
      rsp <= '{hit: res_hit, hit_slot: res_slot, status: res_status};
    end
  end

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RESULT)
    else $error("result word raised outside the result step");

  a_scan_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state) == S_SCAN) |-> cand_idx == $past(cand_idx) + 1'b1)
    else $error("scan skipped or repeated a slot");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && res_hit) |=> (rsp_valid && rsp.hit && !rsp.status))
    else $error("hit reported together with an error status");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.data_en |-> (state == S_WRITE && slot_ok))
    else $error("slot data written outside a valid write");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite box collision table. A directed run
// covers edge cases, then mostly well-formed random traffic follows. Each
// accepted request word updates a shadow slot table, and pair tests and
// first-hit queries queue the answer it predicts. Answers from the block are
// compared field by field in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import sbct_pkg::*;

  localparam int NSLOT        = SPRITE_SLOTS_DEF;
  localparam int NGROUP       = GROUP_COUNT_DEF;
  localparam int RANDOM_WORDS = 950;
  localparam int CYCLE_LIMIT  = 800000;
  // drain window, longer than a full scan, to catch stray words
  localparam int DRAIN_CYCLES = 2 * (4 + NSLOT);

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_CLOGGED
  } rx_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  sprite_box_collision_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // shadow slot table, extents kept already scaled, in 1/256 pixel
  longint box_px    [NSLOT];
  longint box_py    [NSLOT];
  longint box_w     [NSLOT];
  longint box_h     [NSLOT];
  bit     slot_used [NSLOT];
  bit     slot_vis  [NSLOT];
  int     slot_grp  [NSLOT];

  req_t     word_q[$];
  rsp_t     answer_q[$];
  int       total_words;
  int       accepted_cnt = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  bit       word_taken   = 1'b0;
  int       burst_left   = 1;
  int       gap_left     = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_left      = 0;
  rsp_t     got_answer;
  rsp_t     new_answer;

  function automatic bit boxes_meet(input int a, input int b);
    return box_px[a] < box_px[b] + box_w[b] && box_px[a] + box_w[a] > box_px[b] &&
           box_py[a] < box_py[b] + box_h[b] && box_py[a] + box_h[a] > box_py[b];
  endfunction

  // update the shadow table, return 1 when the word yields an answer
  function automatic bit table_apply(input req_t w, output rsp_t r);
    int     s;
    int     t;
    int     g;
    int     i;
    bit     found;
    longint sw;
    longint sh;
    s     = int'(w.slot);
    t     = int'(w.other_slot);
    g     = int'(w.group) % NGROUP;
    r     = '0;
    found = 1'b0;
    case (w.op)
      OP_WRITE: begin
        sw = (int'(w.size_w) > SIZE_MAX) ? SIZE_MAX : int'(w.size_w);
        sh = (int'(w.size_h) > SIZE_MAX) ? SIZE_MAX : int'(w.size_h);
        box_px[s]    = longint'($signed(w.pos_x));
        box_py[s]    = longint'($signed(w.pos_y));
        box_w[s]     = sw * longint'(w.scale_x);
        box_h[s]     = sh * longint'(w.scale_y);
        slot_used[s] = 1'b1;
        slot_vis[s]  = w.visible;
        slot_grp[s]  = g;
        return 1'b0;
      end
      OP_DELETE: begin
        slot_used[s] = 1'b0;
        return 1'b0;
      end
      OP_PAIR: begin
        if (!slot_used[s] || !slot_used[t]) begin
          r.status = 1'b1;
        end else if (slot_vis[s] && slot_vis[t]) begin
          r.hit = boxes_meet(s, t);
        end
      end
      default: begin
        if (!slot_used[s]) begin
          r.status = 1'b1;
        end else if (slot_vis[s]) begin
          for (i = 0; i < NSLOT; i++) begin
            if (!found && i != s && slot_used[i] && slot_vis[i] &&
                slot_grp[i] == g && boxes_meet(s, i)) begin
              found      = 1'b1;
              r.hit      = 1'b1;
              r.hit_slot = SLOT_W'(i);
            end
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic req_t noise_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t mk_write(input int s, input int px, input int py,
                                    input int sw, input int sh, input int kx,
                                    input int ky, input bit vis, input int grp);
    req_t w;
    w         = noise_word();
    w.op      = OP_WRITE;
    w.slot    = SLOT_W'(s);
    w.pos_x   = POS_W'(px);
    w.pos_y   = POS_W'(py);
    w.size_w  = SIZE_W'(sw);
    w.size_h  = SIZE_W'(sh);
    w.scale_x = SCALE_W'(kx);
    w.scale_y = SCALE_W'(ky);
    w.visible = vis;
    w.group   = GROUP_W'(grp);
    return w;
  endfunction

  function automatic req_t mk_ask(input op_t op, input int s, input int t, input int grp);
    req_t w;
    w            = noise_word();
    w.op         = op;
    w.slot       = SLOT_W'(s);
    w.other_slot = SLOT_W'(t);
    w.group      = GROUP_W'(grp);
    return w;
  endfunction

  // mostly a small hot set so slots get reused and boxes meet
  function automatic int pick_slot();
    if ($urandom_range(0, 3) != 0) begin
      return $urandom_range(0, 11);
    end
    return $urandom_range(0, NSLOT - 1);
  endfunction

  // append a word to the pending queue
  task automatic add_word(input req_t w);
    word_q = {word_q, w};
  endtask

  task automatic build_directed_words();
    // nothing in use yet
    add_word(mk_ask(OP_PAIR, 0, 1, 0));
    add_word(mk_ask(OP_FIRST, 0, 0, 3));
    add_word(mk_write(0, 0, 0, 16, 16, 256, 256, 1'b1, 3));
    add_word(mk_write(1, 2048, 2048, 16, 16, 256, 256, 1'b1, 3));
    add_word(mk_ask(OP_PAIR, 0, 1, 0));
    add_word(mk_ask(OP_PAIR, 0, 0, 0));
    add_word(mk_ask(OP_FIRST, 0, 0, 3));
    add_word(mk_ask(OP_FIRST, 0, 0, 2));
    // left edge exactly on the right edge of slot 0
    add_word(mk_write(2, 4096, 0, 16, 16, 256, 256, 1'b1, 3));
    add_word(mk_ask(OP_PAIR, 0, 2, 0));
    // zero scaled width
    add_word(mk_write(3, 0, 0, 16, 16, 0, 256, 1'b1, 3));
    add_word(mk_ask(OP_PAIR, 3, 3, 0));
    add_word(mk_ask(OP_PAIR, 0, 3, 0));
    add_word(mk_write(4, 0, 0, 16, 16, 256, 256, 1'b0, 3));
    add_word(mk_ask(OP_PAIR, 0, 4, 0));
    add_word(mk_ask(OP_FIRST, 4, 0, 3));
    // most negative corner, saturated size, largest scale
    add_word(mk_write(5, -8388608, -8388608, 8191, 4096, 65535, 65535, 1'b1, 15));
    add_word(mk_ask(OP_PAIR, 5, 0, 0));
    add_word(mk_ask(OP_FIRST, 5, 0, 3));
    add_word(mk_write(63, 8388607, 8388607, 1, 1, 1, 1, 1'b1, 15));
    add_word(mk_ask(OP_PAIR, 63, 5, 0));
    add_word(mk_ask(OP_FIRST, 63, 0, 15));
    // second delete hits a free slot
    add_word(mk_ask(OP_DELETE, 1, 0, 0));
    add_word(mk_ask(OP_DELETE, 1, 0, 0));
    add_word(mk_ask(OP_PAIR, 0, 1, 0));
    add_word(mk_ask(OP_FIRST, 1, 0, 3));
  endtask

  task automatic build_random_words();
    int   n;
    int   pick;
    int   s;
    int   t;
    req_t w;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      s    = pick_slot();
      t    = pick_slot();
      if (pick < 35) begin
        if ($urandom_range(0, 4) == 0) begin
          // full range of every field but the op and the slot
          w      = noise_word();
          w.op   = OP_WRITE;
          w.slot = SLOT_W'(s);
        end else begin
          w = mk_write(s, $urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192,
                       $urandom_range(0, 48), $urandom_range(0, 48),
                       $urandom_range(0, 512), $urandom_range(0, 512),
                       $urandom_range(0, 4) != 0, $urandom_range(0, 3));
        end
      end else if (pick < 43) begin
        w = mk_ask(OP_DELETE, s, t, $urandom_range(0, 15));
      end else if (pick < 72) begin
        w = mk_ask(OP_PAIR, s, t, $urandom_range(0, 15));
      end else begin
        w = mk_ask(OP_FIRST, s, t,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
      end
      add_word(w);
    end
  endtask

  // request driver: bursts of words with gaps between them
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || word_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          req       <= word_q.pop_front();
          req_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 5);
            end
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
      word_taken = 1'b0;
    end
  end

  // answer side stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(10, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    rsp_stall <= 1'b0;
      RX_CHOPPY:  rsp_stall <= ($urandom_range(0, 2) == 0);
      default:    rsp_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor: check answers first, then take in the accepted request word
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (answer_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected answer word: hit=%0d hit_slot=%0d status=%0d",
                     rsp.hit, rsp.hit_slot, rsp.status);
          end
        end else begin
          got_answer = answer_q.pop_front();
          if (rsp.hit !== got_answer.hit || rsp.hit_slot !== got_answer.hit_slot ||
              rsp.status !== got_answer.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("answer mismatch: expected hit=%0d slot=%0d status=%0d, got %0d %0d %0d",
                       got_answer.hit, got_answer.hit_slot, got_answer.status,
                       rsp.hit, rsp.hit_slot, rsp.status);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        word_taken = 1'b1;
        accepted_cnt++;
        if (table_apply(req, new_answer)) begin
          answer_q = {answer_q, new_answer};
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    build_directed_words();
    build_random_words();
    total_words = word_q.size();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (accepted_cnt < total_words || answer_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
